### design/bsc_pkg.sv
package bsc_pkg;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_TDIV,
        ST_T3,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P5,
        ST_P6,
        ST_P7,
        ST_P8,
        ST_P9,
        ST_P10,
        ST_P11,
        ST_P12,
        ST_P13,
        ST_P14,
        ST_P15,
        ST_P16,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        REG_AC1,
        REG_AC2,
        REG_AC3,
        REG_AC4,
        REG_AC5_AC6,
        REG_B1_B2,
        REG_MC_MD
    } reg_idx_t;

    localparam int unsigned NUM_REGS = 7;

    typedef struct packed {
        logic        start;
        logic        sgn;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        asr32 = 32'($signed(v) >>> s);
    endfunction

endpackage

### design/bsc_div.sv
module bsc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bsc_pkg::div_req_t req,
    output bsc_pkg::div_rsp_t rsp
);
    import bsc_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] an;
    logic [31:0] bn;

    // restoring divider, one quotient bit per cycle, sign fixed at the end
    always_comb
    begin
        an = (req.sgn && req.num[31]) ? (32'd0 - req.num) : req.num;
        bn = (req.sgn && req.den[31]) ? (32'd0 - req.den) : req.den;
        trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            quo_next = an;
            den_next = bn;
            cnt_next = 6'd32;
            busy_next = 1'b1;
            neg_next = req.sgn && (req.num[31] ^ req.den[31]);
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? (32'd0 - quo_reg) : quo_reg;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_cnt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 6'd0) else $error("divider count underflow");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
`endif

endmodule

### design/bsc_alu.sv
module bsc_alu (
    input  bsc_pkg::alu_op_t op,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic [31:0]      y
);
    import bsc_pkg::*;

    // shared 32x32 wrapping multiplier / adder / subtractor
    always_comb
    begin
        unique case (op)
            ALU_MUL: y = 32'(a * b);
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a;
        endcase
    end

endmodule

### design/baro_sensor_compensation_top.sv
// Channel | Dir | Fields, lowest bit first
// s_axis  | in  | tdata: raw_value[15:0]; tuser: op
// m_axis  | out | tdata: temperature_tenths[15:0], pressure_pa[33:16], math_error[34]
//         |     | tuser: result_kind
// apb     | in  | seven calibration registers at byte address 4*i
// Temperature transaction: steps T0, T1, T2, divider wait TDIV, T3, then OUT; T2 goes
// straight to OUT on a zero divisor. Pressure: P0 to P16 with a divider wait in P12,
// P10 going straight to OUT on B4 == 0. Outside the divider waits, the shared ALU does
// one multiply/add per cycle; s_axis_tready is high only in idle, so items never overlap.
// A finished result waits in its own output register; the sequencer stalls in its
// last step only while the previous result is still unaccepted. Reset clears control
// state, B5 and the calibration registers.
module baro_sensor_compensation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // raw_value[15:0]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // temperature_tenths, pressure_pa, math_error, pad
    output logic        m_axis_tuser,   // result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bsc_pkg::*;

    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg;
    logic [31:0] ac56_reg, b12_reg, mcmd_reg;
    logic [31:0] b5_reg, b5_next;
    state_t      st_reg, st_next;
    logic [31:0] acc_reg, acc_next;   // working value / X1
    logic [31:0] t1_reg, t1_next;     // B6 / X2 / p
    logic [31:0] t2_reg, t2_next;     // sq / B7
    logic [31:0] t3_reg, t3_next;     // x-part / B3
    logic        op_reg;
    logic [15:0] raw_reg;
    logic        ov_reg, ov_next;
    logic        err_reg, err_next;
    logic [15:0] tout_reg, tout_next;
    logic [17:0] pout_reg, pout_next;
    logic        res_kind_reg;
    logic        res_err_reg;
    logic [15:0] res_tout_reg;
    logic [17:0] res_pout_reg;
    logic        out_free;
    logic        load_out;
    alu_op_t     aop;
    logic [31:0] aa, ab, ay;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        take;
    logic        wr;
    logic [2:0]  ridx;
    logic [31:0] sq_ac1, sq_ac2, sq_ac3, sq_b1, sq_b2, sq_mc, sq_md;
    logic [31:0] t4;

    assign sq_ac1 = 32'($signed(ac1_reg));
    assign sq_ac2 = 32'($signed(ac2_reg));
    assign sq_ac3 = 32'($signed(ac3_reg));
    assign sq_b1  = 32'($signed(b12_reg[31:16]));
    assign sq_b2  = 32'($signed(b12_reg[15:0]));
    assign sq_mc  = 32'($signed(mcmd_reg[31:16]));
    assign sq_md  = 32'($signed(mcmd_reg[15:0]));

    // APB
    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr     = psel && penable && pwrite && pready;
    always_comb
    begin
        unique case (ridx)
            REG_AC1:     prdata = {16'd0, ac1_reg};
            REG_AC2:     prdata = {16'd0, ac2_reg};
            REG_AC3:     prdata = {16'd0, ac3_reg};
            REG_AC4:     prdata = {16'd0, ac4_reg};
            REG_AC5_AC6: prdata = ac56_reg;
            REG_B1_B2:   prdata = b12_reg;
            REG_MC_MD:   prdata = mcmd_reg;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg <= '0; ac2_reg <= '0; ac3_reg <= '0; ac4_reg <= '0;
            ac56_reg <= '0; b12_reg <= '0; mcmd_reg <= '0;
        end
        else if (wr)
        begin
            unique case (ridx)
                REG_AC1:     ac1_reg  <= pwdata[15:0];
                REG_AC2:     ac2_reg  <= pwdata[15:0];
                REG_AC3:     ac3_reg  <= pwdata[15:0];
                REG_AC4:     ac4_reg  <= pwdata[15:0];
                REG_AC5_AC6: ac56_reg <= pwdata;
                REG_B1_B2:   b12_reg  <= pwdata;
                REG_MC_MD:   mcmd_reg <= pwdata;
                default:     ;
            endcase
        end
    end

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign take = s_axis_tvalid && s_axis_tready;
    // output register free now or emptied at this edge
    assign out_free = !ov_reg || m_axis_tready;

    bsc_alu u_alu (.op(aop), .a(aa), .b(ab), .y(ay));
    bsc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (take) st_next = s_axis_tuser ? ST_P0 : ST_T0;
            ST_T0:   st_next = ST_T1;
            ST_T1:   st_next = ST_T2;
            ST_T2:   st_next = (ay == 32'd0) ? ST_OUT : ST_TDIV;
            ST_TDIV: if (drsp.done) st_next = ST_T3;
            ST_T3:   st_next = ST_OUT;
            ST_P0:   st_next = ST_P1;
            ST_P1:   st_next = ST_P2;
            ST_P2:   st_next = ST_P3;
            ST_P3:   st_next = ST_P4;
            ST_P4:   st_next = ST_P5;
            ST_P5:   st_next = ST_P6;
            ST_P6:   st_next = ST_P7;
            ST_P7:   st_next = ST_P8;
            ST_P8:   st_next = ST_P9;
            ST_P9:   st_next = ST_P10;
            ST_P10:  st_next = (acc_reg == 32'd0) ? ST_OUT : ST_P11;
            ST_P11:  st_next = ST_P12;
            ST_P12:  if (drsp.done) st_next = ST_P13;
            ST_P13:  st_next = ST_P14;
            ST_P14:  st_next = ST_P15;
            ST_P15:  st_next = ST_P16;
            ST_P16:  st_next = ST_OUT;
            ST_OUT:  if (out_free) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // datapath / outputs
    always_comb
    begin
        aop = ALU_ADD; aa = acc_reg; ab = 32'd0;
        acc_next = acc_reg; t1_next = t1_reg; t2_next = t2_reg; t3_next = t3_reg;
        b5_next = b5_reg; err_next = err_reg; tout_next = tout_reg;
        pout_next = pout_reg; ov_next = ov_reg;
        dreq = '0; t4 = '0; load_out = 1'b0;
        if (ov_reg && m_axis_tready) ov_next = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    err_next = 1'b0; tout_next = '0; pout_next = '0;
                end
            end
            ST_T0:
            begin
                aop = ALU_SUB; aa = {16'd0, raw_reg}; ab = {16'd0, ac56_reg[15:0]};
                acc_next = ay;
            end
            ST_T1:
            begin
                aop = ALU_MUL; aa = acc_reg; ab = {16'd0, ac56_reg[31:16]};
                acc_next = asr32(ay, 15);
            end
            ST_T2:
            begin
                aop = ALU_ADD; aa = acc_reg; ab = sq_md;
                t1_next = ay;
                if (ay == 32'd0) err_next = 1'b1;
                dreq.start = (ay != 32'd0); dreq.sgn = 1'b1;
                dreq.num = {sq_mc[20:0], 11'd0}; dreq.den = ay;
            end
            ST_TDIV:
            begin
                if (drsp.done) t1_next = drsp.quo;   // X2
            end
            ST_T3:
            begin
                aop = ALU_ADD; aa = acc_reg; ab = t1_reg;
                b5_next = ay;
                t4 = asr32(ay + 32'd8, 4);
                if ($signed(t4) > 32'sd32767) tout_next = 16'h7FFF;
                else if ($signed(t4) < -32'sd32768) tout_next = 16'h8000;
                else tout_next = t4[15:0];
            end
            ST_P0:
            begin
                aop = ALU_SUB; aa = b5_reg; ab = 32'd4000;
                t1_next = ay;                        // B6
            end
            ST_P1:
            begin
                aop = ALU_MUL; aa = t1_reg; ab = t1_reg;
                t2_next = asr32(ay, 12);             // sq
            end
            ST_P2:
            begin
                aop = ALU_MUL; aa = sq_b2; ab = t2_reg;
                acc_next = asr32(ay, 11);
            end
            ST_P3:
            begin
                aop = ALU_MUL; aa = sq_ac2; ab = t1_reg;
                t3_next = asr32(ay, 11);
            end
            ST_P4:
            begin
                aop = ALU_ADD; aa = acc_reg; ab = t3_reg;
                acc_next = ay + 32'd2;               // X3 + 2
            end
            ST_P5:
            begin
                aop = ALU_ADD; aa = {sq_ac1[29:0], 2'd0}; ab = acc_reg;
                t3_next = asr32(ay, 2);              // B3 in t3
            end
            ST_P6:
            begin
                aop = ALU_MUL; aa = sq_ac3; ab = t1_reg;
                acc_next = asr32(ay, 13);
            end
            ST_P7:
            begin
                aop = ALU_MUL; aa = sq_b1; ab = t2_reg;
                t2_next = asr32(ay, 16);
            end
            ST_P8:
            begin
                aop = ALU_ADD; aa = acc_reg; ab = t2_reg;
                acc_next = asr32(ay + 32'd2, 2) + 32'd32768;
            end
            ST_P9:
            begin
                aop = ALU_MUL; aa = {16'd0, ac4_reg}; ab = acc_reg;
                acc_next = ay >> 15;                 // B4
            end
            ST_P10:
            begin
                aop = ALU_SUB; aa = {16'd0, raw_reg}; ab = t3_reg;
                t2_next = ay;                        // UP - B3
                if (acc_reg == 32'd0) err_next = 1'b1;
            end
            ST_P11:
            begin
                aop = ALU_MUL; aa = t2_reg; ab = 32'd50000;
                t2_next = ay;                        // B7
                dreq.start = 1'b1; dreq.sgn = 1'b0;
                dreq.num = ay[31] ? ay : {ay[30:0], 1'b0}; dreq.den = acc_reg;
            end
            ST_P12:
            begin
                if (drsp.done)
                    t1_next = t2_reg[31] ? {drsp.quo[30:0], 1'b0} : drsp.quo;  // p
            end
            ST_P13:
            begin
                aop = ALU_MUL; aa = asr32(t1_reg, 8); ab = asr32(t1_reg, 8);
                acc_next = ay;
            end
            ST_P14:
            begin
                aop = ALU_MUL; aa = acc_reg; ab = 32'd3038;
                acc_next = asr32(ay, 16);
            end
            ST_P15:
            begin
                aop = ALU_MUL; aa = t1_reg; ab = 32'd0 - 32'd7357;
                acc_next = acc_reg + asr32(ay, 16) + 32'd3791;
            end
            ST_P16:
            begin
                aop = ALU_ADD; aa = t1_reg; ab = asr32(acc_reg, 4);
                if (ay[31]) pout_next = '0;
                else if (ay > 32'd262143) pout_next = 18'h3FFFF;
                else pout_next = ay[17:0];
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    ov_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            b5_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            b5_reg <= b5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        t3_reg   <= t3_next;
        err_reg  <= err_next;
        tout_reg <= tout_next;
        pout_reg <= pout_next;
        if (take)
        begin
            op_reg  <= s_axis_tuser;
            raw_reg <= s_axis_tdata;
        end
        if (load_out)
        begin
            res_kind_reg <= op_reg;
            res_err_reg  <= err_reg;
            res_tout_reg <= tout_reg;
            res_pout_reg <= pout_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = res_kind_reg;
    assign m_axis_tdata  = {5'd0, res_err_reg, res_pout_reg, res_tout_reg};

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_err_reg) |-> (res_tout_reg == 16'd0 && res_pout_reg == 18'd0))
        else $error("error result carries value");
    a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !res_kind_reg) |-> res_pout_reg == 18'd0)
        else $error("pressure in temperature result");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while waiting");
`endif

endmodule

### tb/baro_sensor_compensation_top_tb.sv
`timescale 1ns / 1ps

module baro_sensor_compensation_top_tb;
    import bsc_pkg::*;

    // op codes carried on s_axis_tuser
    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // drain margin after the last result
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic        kind;
        logic [15:0] temp_tenths;
        logic [17:0] press_pa;
        logic        err;
    } comp_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // raw_value[15:0]
    logic        s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // temperature_tenths[15:0], pressure_pa[33:16], math_error[34]
    logic        m_axis_tuser;   // result_kind
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    baro_sensor_compensation_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of calibration and the stored B5
    logic [31:0]  cal_regs [NUM_REGS];
    logic [31:0]  stored_b5;
    comp_result_t expected_results[$];
    int           error_count;
    int           send_idle_pct;
    int           recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] sra(input logic [31:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Integer compensation; updates stored_b5 on a good temperature item.
    function automatic comp_result_t compensate(input logic op, input logic [15:0] raw);
        comp_result_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, raw32;
        longint      t;
        longint      ps;
        ac1 = sx16(cal_regs[REG_AC1][15:0]);
        ac2 = sx16(cal_regs[REG_AC2][15:0]);
        ac3 = sx16(cal_regs[REG_AC3][15:0]);
        ac4 = {16'd0, cal_regs[REG_AC4][15:0]};
        ac5 = {16'd0, cal_regs[REG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal_regs[REG_AC5_AC6][15:0]};
        b1  = sx16(cal_regs[REG_B1_B2][31:16]);
        b2  = sx16(cal_regs[REG_B1_B2][15:0]);
        mc  = sx16(cal_regs[REG_MC_MD][31:16]);
        md  = sx16(cal_regs[REG_MC_MD][15:0]);
        raw32 = {16'd0, raw};
        r = '0;
        r.kind = op;
        if (op == OP_TEMP)
        begin
            x1 = sra((raw32 - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 0)
                r.err = 1'b1;
            else
            begin
                // signed divide truncating toward zero, done in 64 bits
                x2 = 32'(longint'($signed(mc << 11)) / longint'($signed(den)));
                b5 = x1 + x2;
                t = longint'($signed(sra(b5 + 32'd8, 4)));
                stored_b5 = b5;
                if (t > 32767) t = 32767;
                if (t < -32768) t = -32768;
                r.temp_tenths = 16'(t);
            end
        end
        else
        begin
            b6 = stored_b5 - 32'd4000;
            sq = sra(b6 * b6, 12);
            x1 = sra(b2 * sq, 11);
            x2 = sra(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = sra(ac1 * 32'd4 + x3 + 32'd2, 2);
            x1 = sra(ac3 * b6, 13);
            x2 = sra(b1 * sq, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            if (b4 == 0)
                r.err = 1'b1;
            else
            begin
                b7 = (raw32 - b3) * 32'd50000;
                if (b7 < 32'h8000_0000)
                    p = (b7 * 32'd2) / b4;
                else
                    p = (b7 / b4) * 32'd2;
                x1 = sra(p, 8);
                x1 = x1 * x1;
                x1 = sra(x1 * 32'd3038, 16);
                x2 = sra(p * (32'd0 - 32'd7357), 16);
                p = p + sra(x1 + x2 + 32'd3791, 4);
                ps = longint'($signed(p));
                if (ps < 0) ps = 0;
                if (ps > 262143) ps = 262143;
                r.press_pa = 18'(ps);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker and receiver back-pressure
    always @(posedge clk)
    begin
        comp_result_t exp_r;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected transaction", m_axis_tdata[31:0], 32'd0);
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_axis_tuser !== exp_r.kind)
                        report_mismatch("result_kind", 32'(m_axis_tuser), 32'(exp_r.kind));
                    if (m_axis_tdata[15:0] !== exp_r.temp_tenths)
                        report_mismatch("temperature_tenths", 32'(m_axis_tdata[15:0]),
                                        32'(exp_r.temp_tenths));
                    if (m_axis_tdata[33:16] !== exp_r.press_pa)
                        report_mismatch("pressure_pa", 32'(m_axis_tdata[33:16]),
                                        32'(exp_r.press_pa));
                    if (m_axis_tdata[34] !== exp_r.err)
                        report_mismatch("math_error", 32'(m_axis_tdata[34]),
                                        32'(exp_r.err));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one transaction on s_axis; prediction made at acceptance
    // tvalid stays high after acceptance until the next idle or drain
    task automatic send_reading(input logic op, input logic [15:0] raw);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= raw;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(compensate(op, raw));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup then access; only while idle
    task automatic write_cal(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cal_regs[idx] = (idx < REG_AC5_AC6) ? {16'd0, val[15:0]} : val;
    endtask

    task automatic load_cal(input logic [15:0] a1, input logic [15:0] a2,
                            input logic [15:0] a3, input logic [15:0] a4,
                            input logic [31:0] a56, input logic [31:0] bb,
                            input logic [31:0] mm);
        write_cal(REG_AC1, {16'd0, a1});
        write_cal(REG_AC2, {16'd0, a2});
        write_cal(REG_AC3, {16'd0, a3});
        write_cal(REG_AC4, {16'd0, a4});
        write_cal(REG_AC5_AC6, a56);
        write_cal(REG_B1_B2, bb);
        write_cal(REG_MC_MD, mm);
    endtask

    // datasheet example coefficients
    task automatic load_typical_cal();
        load_cal(16'd408, -16'sd72, -16'sd14383, 16'd32741, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    endtask

    // zero calibration after reset: temperature divisor zero, pressure B4 zero
    task automatic test_reset_defaults();
        send_reading(OP_PRESS, 16'd0);
        send_reading(OP_TEMP, 16'hFFFF);
        send_reading(OP_PRESS, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_directed();
        load_typical_cal();
        send_reading(OP_TEMP, 16'd27898);
        send_reading(OP_PRESS, 16'd23843);
        send_reading(OP_PRESS, 16'd0);
        send_reading(OP_PRESS, 16'hFFFF);
        send_reading(OP_TEMP, 16'd0);
        send_reading(OP_TEMP, 16'hFFFF);
        send_reading(OP_PRESS, 16'h5555);
        send_reading(OP_PRESS, 16'hAAAA);
        wait_drained();
        // extremes: wrapping intermediates and saturation
        load_cal(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 32'hFFFF_0000,
                 32'h7FFF_8000, 32'h8000_7FFF);
        send_reading(OP_TEMP, 16'hFFFF);
        send_reading(OP_PRESS, 16'h0000);
        send_reading(OP_TEMP, 16'h0000);
        send_reading(OP_PRESS, 16'hFFFF);
        wait_drained();
        load_cal(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 32'h0000_FFFF,
                 32'h8000_7FFF, 32'h7FFF_8000);
        send_reading(OP_TEMP, 16'h1234);
        send_reading(OP_PRESS, 16'hFEDC);
        wait_drained();
        // zero temperature divisor with valid B5 kept: AC5=0 gives X1=0, MD=0
        load_cal(16'd408, -16'sd72, -16'sd14383, 16'd32741, {16'd0, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd0});
        send_reading(OP_TEMP, 16'd27898);
        send_reading(OP_PRESS, 16'd23843);
        wait_drained();
        // pressure B4 zero: AC4 = 0
        load_cal(16'd408, -16'sd72, -16'sd14383, 16'd0, {16'd32757, 16'd23153},
                 {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
        send_reading(OP_PRESS, 16'd23843);
        wait_drained();
    endtask

    // mostly temperature-then-pressure pairs near typical data, some noise
    task automatic run_random(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(3) != 0)
            begin
                send_reading(OP_TEMP, 16'($urandom_range(22000, 34000)));
                send_reading(OP_PRESS, 16'($urandom_range(15000, 40000)));
                k++;
            end
            else
                send_reading(1'($urandom), 16'($urandom));
            if (k == n / 2)
                wait_drained();   // sender holds off until all results are in
        end
    endtask

    task automatic test_random_phase(input int sidle, input int ridle, input int n);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        case ($urandom_range(2))
            0: load_typical_cal();
            1: load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        $urandom, $urandom, $urandom);
            default: load_cal(16'($urandom_range(0, 2000)), -16'sd72, -16'sd14383,
                              16'($urandom_range(30000, 34000)),
                              {16'($urandom_range(30000, 34000)), 16'($urandom)},
                              {16'd6190, 16'($urandom_range(0, 8))},
                              {-16'sd8711, 16'($urandom_range(2000, 3000))});
        endcase
        run_random(n);
        wait_drained();
    endtask

    initial
    begin
        int ph;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        stored_b5 = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (cal_regs[i]) cal_regs[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        // idling profiles, two phases each, a calibration loaded per phase
        for (ph = 0; ph < 6; ph++)
        begin
            if (ph < 2)
                test_random_phase(27, 48, 256);
            else if (ph < 4)
                test_random_phase(48, 27, 256);
            else
                test_random_phase(0, 0, 256);
        end

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
